@@ hdl/signed_distance_primitives_defines.svh @@
// Assertion macros shared by the signed distance checker.
// No dependencies.
`ifndef SIGNED_DISTANCE_PRIMITIVES_DEFINES_SVH
`define SIGNED_DISTANCE_PRIMITIVES_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/sdp_pkg.sv @@
// Types and constants of the signed distance evaluator.
// No dependencies; used by the top level and the checker.
package sdp_pkg;

  localparam logic [2:0] KIND_PLANE   = 3'd0;
  localparam logic [2:0] KIND_BOX     = 3'd1;
  localparam logic [2:0] KIND_IBOX    = 3'd2;
  localparam logic [2:0] KIND_SPHERE  = 3'd3;
  localparam logic [2:0] KIND_ISPHERE = 3'd4;

  localparam int SQ_STEPS   = 32;
  localparam int DIV_STEPS  = 29;
  localparam int UNIT_SHIFT = 28;

  localparam logic [31:0] MAX32     = 32'h7fff_ffff;
  localparam logic [31:0] MIN32     = 32'h8000_0000;
  localparam logic [63:0] HALF_UNIT = 64'd1 << (UNIT_SHIFT - 1);

  typedef struct packed {
    logic        [2:0]  kind;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic        [30:0] radius;
  } req_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic               degenerate;
  } rsp_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic              degen;
    logic              ovf;
    logic [31:0]       res;
    logic [2:0][32:0]  d;
    logic [2:0]        nneg;
    logic [2:0][31:0]  nm;
    logic [30:0]       radius;
  } car_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  typedef struct packed {
    logic [2:0][32:0]          p;
    logic [2:0][DIV_STEPS-1:0] q;
    logic [31:0]               len;
  } dv_t;

endpackage

@@ hdl/signed_distance_primitives.sv @@
// Signed distance evaluator for plane, box and sphere primitives.
// One request enters every cycle unless req_stall is high; the square root has
// 32 stages and the divider 29.
// The output register and a one-entry skid buffer let a new request in while
// a result waits. Reset clears all valid bits; payload registers are not reset.
// Depends on sdp_pkg.
module signed_distance_primitives
  import sdp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [31:0] sat36(input logic [35:0] x);
    if ($signed(x) > $signed({4'h0, MAX32})) begin
      return MAX32;
    end else if ($signed(x) < $signed({4'hf, MIN32})) begin
      return MIN32;
    end
    return x[31:0];
  endfunction

  function automatic sq_t sq_step(input sq_t x);
    sq_t         y;
    logic [34:0] sh;
    logic [34:0] trial;
    sh    = {x.rem[32:0], x.rad[63:62]};
    trial = {1'b0, x.root, 2'b01};
    y.rad = {x.rad[61:0], 2'b00};
    if (sh >= trial) begin
      y.rem  = sh - trial;
      y.root = {x.root[30:0], 1'b1};
    end else begin
      y.rem  = sh;
      y.root = {x.root[30:0], 1'b0};
    end
    return y;
  endfunction

  function automatic dv_t dv_step(input dv_t x);
    dv_t         y;
    logic        ge;
    logic [32:0] t;
    y.len = x.len;
    for (int i = 0; i < 3; i++) begin
      ge = x.p[i] >= {1'b0, x.len};
      t  = ge ? (x.p[i] - {1'b0, x.len}) : x.p[i];
      y.p[i] = {t[31:0], 1'b0};
      y.q[i] = {x.q[i][DIV_STEPS-2:0], ge};
    end
    return y;
  endfunction

  logic en;
  logic skid_valid;
  rsp_t skid;

  assign en        = !skid_valid;
  assign req_stall = skid_valid;

  // Stage 1: differences and normal magnitudes.
  logic             v1;
  car_t             c1;
  logic [2:0][31:0] vec1;
  logic [2:0][31:0] pin;
  logic [2:0][31:0] cin;
  logic [2:0][31:0] vin;

  assign pin = {req.point_z, req.point_y, req.point_x};
  assign cin = {req.centre_z, req.centre_y, req.centre_x};
  assign vin = {req.vec_z, req.vec_y, req.vec_x};

  always_ff @(posedge clk) begin
    if (en) begin
      c1.kind   <= req.kind;
      c1.degen  <= 1'b0;
      c1.ovf    <= 1'b0;
      c1.res    <= '0;
      c1.radius <= req.radius;
      for (int i = 0; i < 3; i++) begin
        c1.d[i]    <= {pin[i][31], pin[i]} - {cin[i][31], cin[i]};
        c1.nm[i]   <= abs32(vin[i]);
        c1.nneg[i] <= vin[i][31];
        vec1[i]    <= vin[i];
      end
    end
  end

  // Stage 2: box face terms 2|d| - size.
  logic             v2;
  car_t             c2;
  logic [2:0][32:0] ad2;
  logic [2:0][34:0] u2;

  always_ff @(posedge clk) begin
    if (en) begin
      c2     <= c1;
      c2.ovf <= c1.d[0][32] ? (c1.d[0] == 33'h1_0000_0000) : 1'b0;
      for (int i = 0; i < 3; i++) begin
        ad2[i] <= c1.d[i][32] ? (~c1.d[i] + 33'd1) : c1.d[i];
        u2[i]  <= {1'b0, (c1.d[i][32] ? (~c1.d[i] + 33'd1) : c1.d[i]), 1'b0}
                  - {{3{vec1[i][31]}}, vec1[i]};
      end
    end
  end

  // Stage 3: largest normal component and largest face term.
  logic             v3;
  car_t             c3;
  logic [2:0][32:0] ad3;
  logic [31:0]      big3;
  logic [34:0]      mx3;
  logic [31:0]      big01;
  logic [34:0]      mx01;

  always_comb begin
    big01 = (c2.nm[0] > c2.nm[1]) ? c2.nm[0] : c2.nm[1];
    mx01  = ($signed(u2[0]) > $signed(u2[1])) ? u2[0] : u2[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3     <= c2;
      c3.ovf <= ad2[0][32] | ad2[1][32] | ad2[2][32];
      ad3    <= ad2;
      big3   <= (big01 > c2.nm[2]) ? big01 : c2.nm[2];
      mx3    <= ($signed(mx01) > $signed(u2[2])) ? mx01 : u2[2];
    end
  end

  // Stage 4: coarse normalization of the normal and the box result.
  logic             v4;
  car_t             c4;
  logic [2:0][32:0] ad4;
  logic [31:0]      big4;
  logic [31:0]      b4n;
  logic [2:0][31:0] m4n;
  logic [34:0]      best;
  logic [34:0]      bhalf;

  always_comb begin
    b4n = big3;
    m4n = c3.nm;
    if (b4n[31:15] == '0) begin
      b4n = b4n << 16;
      for (int i = 0; i < 3; i++) m4n[i] = m4n[i] << 16;
    end
    if (b4n[31:23] == '0) begin
      b4n = b4n << 8;
      for (int i = 0; i < 3; i++) m4n[i] = m4n[i] << 8;
    end
    best  = (c3.kind == KIND_IBOX) ? (~mx3 + 35'd1) : mx3;
    bhalf = 35'($signed(best + 35'd1) >>> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4     <= c3;
      c4.nm  <= m4n;
      c4.res <= sat36({bhalf[34], bhalf});
      ad4    <= ad3;
      big4   <= b4n;
    end
  end

  // Stage 5: fine normalization and zero-normal detection.
  logic             v5;
  car_t             c5;
  logic [2:0][32:0] ad5;
  logic [31:0]      b5n;
  logic [2:0][31:0] m5n;

  always_comb begin
    b5n = big4;
    m5n = c4.nm;
    if (b5n[31:27] == '0) begin
      b5n = b5n << 4;
      for (int i = 0; i < 3; i++) m5n[i] = m5n[i] << 4;
    end
    if (b5n[31:29] == '0) begin
      b5n = b5n << 2;
      for (int i = 0; i < 3; i++) m5n[i] = m5n[i] << 2;
    end
    if (b5n[31:30] == '0) begin
      for (int i = 0; i < 3; i++) m5n[i] = m5n[i] << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5       <= c4;
      c5.nm    <= m5n;
      c5.degen <= (c4.kind == KIND_PLANE) && (big4 == '0);
      ad5      <= ad4;
    end
  end

  // Stage 6: squares of the scaled normal or of the offset.
  logic             v6;
  car_t             c6;
  logic [2:0][63:0] sq6;
  logic [2:0][31:0] a6;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a6[i] = (c5.kind == KIND_PLANE) ? c5.nm[i] : ad5[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c6 <= c5;
      for (int i = 0; i < 3; i++) sq6[i] <= {32'd0, a6[i]} * {32'd0, a6[i]};
    end
  end

  // Stage 7: sum of squares.
  logic        v7;
  car_t        c7;
  logic [63:0] sum7;
  logic [65:0] sum66;

  assign sum66 = {2'b00, sq6[0]} + {2'b00, sq6[1]} + {2'b00, sq6[2]};

  always_ff @(posedge clk) begin
    if (en) begin
      c7     <= c6;
      c7.ovf <= c6.ovf | (sum66[65:64] != 2'b00);
      sum7   <= sum66[63:0];
    end
  end

  // Square root, one result bit per stage.
  sq_t  sq [SQ_STEPS];
  car_t cs [SQ_STEPS];
  logic vs [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    sq_t  sp;
    car_t cp;
    logic vp;
    if (j == 0) begin : g_head
      assign sp = '{rem: '0, root: '0, rad: sum7};
      assign cp = c7;
      assign vp = v7;
    end else begin : g_body
      assign sp = sq[j-1];
      assign cp = cs[j-1];
      assign vp = vs[j-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j] <= 1'b0;
      end else if (en) begin
        vs[j] <= vp;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq[j] <= sq_step(sp);
        cs[j] <= cp;
      end
    end
  end

  // Round the root to nearest.
  logic        vr;
  car_t        cr;
  logic [32:0] lenr;

  always_ff @(posedge clk) begin
    if (en) begin
      cr   <= cs[SQ_STEPS-1];
      lenr <= {1'b0, sq[SQ_STEPS-1].root}
              + {32'd0, (sq[SQ_STEPS-1].rem > {3'b000, sq[SQ_STEPS-1].root})};
    end
  end

  // Sphere result and divider setup.
  logic        vd0;
  car_t        cd0;
  dv_t         dv0;
  logic [33:0] sdiff;
  logic [31:0] sres;

  always_comb begin
    if (cr.kind == KIND_ISPHERE) begin
      sdiff = {3'b000, cr.radius} - {1'b0, lenr};
    end else begin
      sdiff = {1'b0, lenr} - {3'b000, cr.radius};
    end
    if (cr.ovf) begin
      sres = (cr.kind == KIND_ISPHERE) ? MIN32 : MAX32;
    end else begin
      sres = sat36({{2{sdiff[33]}}, sdiff});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd0 <= cr;
      if (cr.kind == KIND_SPHERE || cr.kind == KIND_ISPHERE) begin
        cd0.res <= sres;
      end
      dv0.len <= lenr[31:0];
      for (int i = 0; i < 3; i++) begin
        dv0.p[i] <= {1'b0, cr.nm[i]};
        dv0.q[i] <= '0;
      end
    end
  end

  // Unit normal components, one quotient bit per stage.
  dv_t  dv [DIV_STEPS];
  car_t cdv [DIV_STEPS];
  logic vdv [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
    dv_t  dp;
    car_t cp;
    logic vp;
    if (j == 0) begin : g_head
      assign dp = dv0;
      assign cp = cd0;
      assign vp = vd0;
    end else begin : g_body
      assign dp = dv[j-1];
      assign cp = cdv[j-1];
      assign vp = vdv[j-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vdv[j] <= 1'b0;
      end else if (en) begin
        vdv[j] <= vp;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[j]  <= dv_step(dp);
        cdv[j] <= cp;
      end
    end
  end

  // Signed unit components.
  logic                   vu;
  car_t                   cu;
  logic [2:0][DIV_STEPS:0] uu;

  always_ff @(posedge clk) begin
    if (en) begin
      cu <= cdv[DIV_STEPS-1];
      for (int i = 0; i < 3; i++) begin
        if (cdv[DIV_STEPS-1].nneg[i]) begin
          uu[i] <= ~{1'b0, dv[DIV_STEPS-1].q[i]} + 30'd1;
        end else begin
          uu[i] <= {1'b0, dv[DIV_STEPS-1].q[i]};
        end
      end
    end
  end

  // Products of offset and unit normal.
  logic             vm;
  car_t             cm;
  logic [2:0][62:0] pr;

  always_ff @(posedge clk) begin
    if (en) begin
      cm <= cu;
      for (int i = 0; i < 3; i++) begin
        pr[i] <= $signed({{30{cu.d[i][32]}}, cu.d[i]})
                 * $signed({{33{uu[i][DIV_STEPS]}}, uu[i]});
      end
    end
  end

  // Dot product, rounding and final selection.
  logic        vt;
  car_t        ct;
  logic [63:0] dot;
  logic [63:0] dsh;

  always_comb begin
    dot = {pr[0][62], pr[0]} + {pr[1][62], pr[1]} + {pr[2][62], pr[2]} + HALF_UNIT;
    dsh = 64'($signed(dot) >>> UNIT_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ct <= cm;
      if (cm.kind == KIND_PLANE) begin
        ct.res <= cm.degen ? '0 : sat36(dsh[35:0]);
      end else if (cm.kind != KIND_BOX && cm.kind != KIND_IBOX &&
                   cm.kind != KIND_SPHERE && cm.kind != KIND_ISPHERE) begin
        ct.res <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      vr  <= 1'b0;
      vd0 <= 1'b0;
      vu  <= 1'b0;
      vm  <= 1'b0;
      vt  <= 1'b0;
    end else if (en) begin
      v1  <= req_valid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      vr  <= vs[SQ_STEPS-1];
      vd0 <= vr;
      vu  <= vdv[DIV_STEPS-1];
      vm  <= vu;
      vt  <= vm;
    end
  end

  // Output register with a one-entry skid buffer.
  rsp_t fin;

  always_comb begin
    fin.distance   = ct.res;
    fin.degenerate = ct.degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp_valid && rsp_stall) begin
      if (en && vt) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      rsp_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      rsp_valid <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_stall) begin
      if (en && vt) begin
        skid <= fin;
      end
    end else if (skid_valid) begin
      rsp <= skid;
    end else begin
      rsp <= fin;
    end
  end

endmodule

@@ hdl/sdp_checker.sv @@
// Port-level assertions for the signed distance evaluator, bound to the top.
// Depends on sdp_pkg and signed_distance_primitives_defines.svh.
`include "signed_distance_primitives_defines.svh"
module sdp_checker
  import sdp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  `SDP_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
  `SDP_ASSERT_NOW(a_degen_zero, clk, rst, rsp_valid && rsp.degenerate, rsp.distance == '0, "degenerate result is not zero")
  `SDP_ASSERT_NOW(a_stall_cause, clk, rst, req_stall, $past(rsp_valid && rsp_stall), "request stalled without a stalled result")
  `SDP_ASSERT_NOW(a_stall_out, clk, rst, req_stall, rsp_valid, "request stalled while no result is offered")

endmodule

bind signed_distance_primitives sdp_checker u_sdp_checker (.*);
